FILE: hdl/dfcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcb_pkg
// Shared types and constants for the delayed fade color blend block.
// ----------------------------------------------------------------------------
package dfcb_pkg;

  localparam int TIMER_BITS = 24;
  localparam int CNT_W      = TIMER_BITS + 1;
  localparam int W_W        = 17;               // Q1.16 weight
  localparam int S_W        = 33;               // Q4.12 x Q1.16 strength
  localparam int CH_W       = 16;               // Q2.14 channel
  localparam int PROD_W     = CH_W + S_W;
  localparam int N_CH       = 3;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = 1;
  localparam int Q_CW       = Q_AW + 1;

  localparam logic [W_W-1:0]  ONE_Q16 = 17'h10000;
  localparam logic [CH_W-1:0] ONE_Q14 = 16'h4000;

  localparam logic [2:0] REG_TARGET_COLOR    = 3'd0;
  localparam logic [2:0] REG_BLEND_MODE      = 3'd1;
  localparam logic [2:0] REG_INTENSITY       = 3'd2;
  localparam logic [2:0] REG_INITIAL_DELAY   = 3'd3;
  localparam logic [2:0] REG_ACTIVE_DURATION = 3'd4;
  localparam logic [2:0] REG_FADE_IN_STEP    = 3'd5;
  localparam logic [2:0] REG_FADE_OUT_STEP   = 3'd6;

  localparam logic BLEND_MUL = 1'b0;
  localparam logic BLEND_ADD = 1'b1;

  typedef struct packed {
    logic [3*CH_W-1:0]     target_color;
    logic                  blend_mode;
    logic [15:0]           intensity;
    logic [TIMER_BITS-1:0] initial_delay;
    logic [TIMER_BITS-1:0] active_duration;
    logic [W_W-1:0]        fade_in_step;
    logic [W_W-1:0]        fade_out_step;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hdl/delayed_fade_color_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_fade_color_blend
// Delayed, fading color blend factor generator, one result per frame tick.
// ----------------------------------------------------------------------------
// A result is valid once its frame request has passed through the queue and
// the back end blend sequencer (strength multiply, channel multiply, rounding,
// output hold), which takes no new entry until its last result is handed off.
// The front takes up to two requests ahead through its queue.
// Reset (rst, synchronous): timer disarmed, weight 0, queue empty, registers
// return to their defaults. Config port is always ready.
module delayed_fade_color_blend import dfcb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               gate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        weight,
  output logic signed [31:0] mul_red,
  output logic signed [31:0] mul_green,
  output logic signed [31:0] mul_blue,
  output logic [30:0]        add_red,
  output logic [30:0]        add_green,
  output logic [30:0]        add_blue,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  cfg_t           cfg;
  q_status_t      q_stat;
  logic           push;
  logic           pop;
  logic [W_W-1:0] push_weight;
  logic [W_W-1:0] head_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_color    <= '0;
      cfg.blend_mode      <= BLEND_MUL;
      cfg.intensity       <= 16'd4096;
      cfg.initial_delay   <= '0;
      cfg.active_duration <= '0;
      cfg.fade_in_step    <= ONE_Q16;
      cfg.fade_out_step   <= ONE_Q16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_COLOR:    cfg.target_color    <= cfg_data;
        REG_BLEND_MODE:      cfg.blend_mode      <= cfg_data[0];
        REG_INTENSITY:       cfg.intensity       <= cfg_data[15:0];
        REG_INITIAL_DELAY:   cfg.initial_delay   <= cfg_data[TIMER_BITS-1:0];
        REG_ACTIVE_DURATION: cfg.active_duration <= cfg_data[TIMER_BITS-1:0];
        REG_FADE_IN_STEP:    cfg.fade_in_step    <= cfg_data[W_W-1:0];
        REG_FADE_OUT_STEP:   cfg.fade_out_step   <= cfg_data[W_W-1:0];
        default: ;
      endcase
    end
  end

  dfcb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .gate        (gate),
    .q_stat      (q_stat),
    .push        (push),
    .push_weight (push_weight)
  );

  dfcb_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_weight (push_weight),
    .pop         (pop),
    .head_weight (head_weight),
    .q_stat      (q_stat)
  );

  dfcb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_stat      (q_stat),
    .head_weight (head_weight),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .weight      (weight),
    .mul_red     (mul_red),
    .mul_green   (mul_green),
    .mul_blue    (mul_blue),
    .add_red     (add_red),
    .add_green   (add_green),
    .add_blue    (add_blue)
  );

endmodule

FILE: hdl/dfcb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcb_front
// Frame timer and fade weight recurrence; pushes each new weight to the queue.
// ----------------------------------------------------------------------------
module dfcb_front import dfcb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           gate,
  input  q_status_t      q_stat,
  output logic           push,
  output logic [W_W-1:0] push_weight
);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic             armed;
  logic             armed_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [W_W-1:0]   fade_weight;
  logic [W_W-1:0]   fade_weight_next;

  logic [CNT_W-1:0] elapsed;
  logic [CNT_W:0]   since;
  logic [W_W-1:0]   target;
  logic [W_W-1:0]   step_in;
  logic [W_W-1:0]   step_out;
  logic [W_W:0]     sum;
  logic [W_W-1:0]   diff;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    elapsed  = armed ? cnt : '0;
    since    = {1'b0, elapsed} - {2'b00, cfg.initial_delay};
    target   = '0;
    cnt_next = cnt;
    if (!gate) begin
      armed_next = 1'b0;
    end else begin
      armed_next = 1'b1;
      if (elapsed >= {1'b0, cfg.initial_delay}) begin
        if (cfg.active_duration == '0 || since < {2'b00, cfg.active_duration}) begin
          target = ONE_Q16;
        end
      end
      cnt_next = (elapsed < CNT_MAX) ? elapsed + 1'b1 : elapsed;
    end

    // a zero step means a full step
    step_in  = (cfg.fade_in_step == '0) ? ONE_Q16 : cfg.fade_in_step;
    step_out = (cfg.fade_out_step == '0) ? ONE_Q16 : cfg.fade_out_step;
    sum      = {1'b0, fade_weight} + {1'b0, step_in};
    diff     = fade_weight - target;

    fade_weight_next = fade_weight;
    if (fade_weight < target) begin
      fade_weight_next = (sum > {1'b0, target}) ? target : sum[W_W-1:0];
    end else if (fade_weight > target) begin
      fade_weight_next = (diff <= step_out) ? target : fade_weight - step_out;
    end
  end

  assign push_weight = fade_weight_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      cnt         <= '0;
      fade_weight <= '0;
    end else if (push) begin
      armed       <= armed_next;
      cnt         <= cnt_next;
      fade_weight <= fade_weight_next;
    end
  end

endmodule

FILE: hdl/dfcb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcb_queue
// Two-entry weight queue between the timer front and the blend back end.
// ----------------------------------------------------------------------------
module dfcb_queue import dfcb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [W_W-1:0] push_weight,
  input  logic           pop,
  output logic [W_W-1:0] head_weight,
  output q_status_t      q_stat
);

  logic [W_W-1:0] mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign q_stat.full  = (count == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head_weight  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/dfcb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfcb_back
// Blend sequencer: strength, per-channel product, rounding, output register.
// ----------------------------------------------------------------------------
module dfcb_back import dfcb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  q_status_t          q_stat,
  input  logic [W_W-1:0]     head_weight,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [W_W-1:0]     weight,
  output logic signed [31:0] mul_red,
  output logic signed [31:0] mul_green,
  output logic signed [31:0] mul_blue,
  output logic [30:0]        add_red,
  output logic [30:0]        add_green,
  output logic [30:0]        add_blue
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STR  = 3'd1;
  localparam logic [2:0] ST_PRD  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << 25;
  localparam int Q_W = PROD_W + 1 - 26;

  logic [2:0]        state;
  logic [W_W-1:0]    w_r;
  logic [S_W-1:0]    s_r;
  logic [PROD_W-1:0] prod [N_CH];
  logic [N_CH-1:0]   neg_r;
  logic [31:0]       mul_q [N_CH];
  logic [30:0]       add_q [N_CH];

  assign pop = (state == ST_IDLE) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            state <= ST_STR;
          end
        end
        ST_STR:  state <= ST_PRD;
        ST_PRD:  state <= ST_RND;
        ST_RND: begin
          state     <= ST_DONE;
          out_valid <= 1'b1;
        end
        ST_DONE: begin
          if (!out_stall) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // datapath; one multiplier per channel shared by both blend modes
  always_ff @(posedge clk) begin
    logic [CH_W-1:0]   c;
    logic [CH_W-1:0]   mag;
    logic [CH_W-1:0]   op;
    logic [PROD_W:0]   rsum;
    logic [Q_W-1:0]    q;
    if (pop) begin
      w_r <= head_weight;
    end
    if (state == ST_STR) begin
      s_r <= S_W'(cfg.intensity * w_r);
    end
    for (int k = 0; k < N_CH; k++) begin
      c   = cfg.target_color[k*CH_W +: CH_W];
      mag = (c < ONE_Q14) ? ONE_Q14 - c : c - ONE_Q14;
      op  = (cfg.blend_mode == BLEND_ADD) ? c : mag;
      if (state == ST_PRD) begin
        prod[k]  <= PROD_W'(op * s_r);
        neg_r[k] <= (c < ONE_Q14);
      end
      // q stays below 2^22, so neither result can reach its saturation bound
      rsum = {1'b0, prod[k]} + RND_HALF;
      q    = rsum[PROD_W:26];
      if (state == ST_RND) begin
        if (cfg.blend_mode == BLEND_ADD) begin
          mul_q[k] <= 32'(ONE_Q16);
          add_q[k] <= 31'(q);
        end else begin
          mul_q[k] <= neg_r[k] ? 32'(ONE_Q16) - 32'(q) : 32'(ONE_Q16) + 32'(q);
          add_q[k] <= '0;
        end
      end
    end
    if (state == ST_RND) begin
      weight <= w_r;
    end
  end

  assign mul_red   = mul_q[0];
  assign mul_green = mul_q[1];
  assign mul_blue  = mul_q[2];
  assign add_red   = add_q[0];
  assign add_green = add_q[1];
  assign add_blue  = add_q[2];

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_STR)
    else $error("pop did not start a blend sequence");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_stall) |=> (state == ST_DONE && out_valid))
    else $error("result dropped while stalled");

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_DONE)
    else $error("out_valid outside done state");

  a_mul_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfg.blend_mode == BLEND_MUL) |->
      (add_red == '0 && add_green == '0 && add_blue == '0))
    else $error("additive terms nonzero in multiply mode");

  a_add_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfg.blend_mode == BLEND_ADD) |->
      (mul_red == 32'sd65536 && mul_green == 32'sd65536 && mul_blue == 32'sd65536))
    else $error("multiply factors not unity in additive mode");
`endif

endmodule
